@@ src/fbpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned STRIDE_W    = SIZE_W + 1;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned RED_ZONE    = 32;
  localparam int unsigned BLK_BYTES_RESET = 128;

  localparam logic [CFG_IDX_W-1:0] REG_BLK_BYTES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_SIZE_ZERO  = 3'd1,
    STAT_TOO_BIG    = 3'd2,
    STAT_NO_BLOCK   = 3'd3,
    STAT_BAD_INDEX  = 3'd4,
    STAT_FULL       = 3'd5,
    STAT_NULL_FREE  = 3'd6
  } status_t;

endpackage

`default_nettype wire

@@ src/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pool allocator of NUM_BLOCKS equal blocks, each of the configured usable size plus a
// 32-byte red zone, with free block indices kept on a LIFO stack (index NUM_BLOCKS-1 on
// top after reset). One request is handled at a time; a result sits in an output
// register and the next request is taken only once that result leaves (it may leave in
// the same cycle). Refused requests (size zero, too big, empty stack, null free, full
// stack) are answered from the idle state, and an allocate that pops an invalid index
// is answered after the stack read. An allocate runs a stack read, eight shift-add
// steps for index times stride, and the base add. A free runs the offset subtract, 32
// restoring-division steps by the stride and the push. These steps all go through
// one shared 33-bit add/subtract unit, one product or quotient bit per cycle. The stack
// needs no clearing pass: entries below a low-water mark read as their own position.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [SIZE_W-1:0]    in_request_size,
  input  wire logic [ADDR_W-1:0]    in_free_address,
  input  wire logic                 in_address_is_null,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_W-1:0]         out_block_address,
  output logic [2:0]                out_status
);

  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_BASE,
    S_DIV,
    S_PUSH
  } state_t;

  state_t                state_r, state_nxt;
  logic [SIZE_W-1:0]     blk_bytes_r, blk_bytes_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         low_r, low_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [ADDR_W-1:0]     acc_r, acc_nxt;
  logic [STRIDE_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  status_t               out_status_r, out_status_nxt;

  logic [IDX_W-1:0]      mem [NUM_BLOCKS];
  logic [IDX_W-1:0]      rd_mem_r;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         rd_addr, wr_addr;

  logic [STRIDE_W-1:0]   stride;
  logic [ADDR_W-1:0]     op_a, op_b;
  logic                  op_sub;
  logic [ADDR_W:0]       sum;
  logic                  out_free, accept;
  logic [CW-1:0]         count_m1;
  logic [IDX_W-1:0]      popped;
  logic                  ge;

  assign stride   = STRIDE_W'(blk_bytes_r) + STRIDE_W'(RED_ZONE);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign count_m1 = count_r - CW'(1);
  assign popped   = fresh_r ? IDX_W'(pos_r) : rd_mem_r;
  assign ge       = !sum[ADDR_W];

  // shared add/subtract unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state_r)
      S_IDLE: begin
        op_a   = in_free_address;
        op_b   = base_r;
        op_sub = 1'b1;
      end
      S_MUL: begin
        op_a = {acc_r[ADDR_W-2:0], 1'b0};
        op_b = idx_r[IDX_W-1] ? ADDR_W'(stride) : '0;
      end
      S_BASE: begin
        op_a = acc_r;
        op_b = base_r;
      end
      S_DIV: begin
        op_a   = ADDR_W'({rem_r, quo_r[ADDR_W-1]});
        op_b   = ADDR_W'(stride);
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
    sum = {1'b0, op_a} + ({1'b0, op_b} ^ {(ADDR_W+1){op_sub}}) + (ADDR_W+1)'(op_sub);
  end

  always_comb begin
    state_nxt      = state_r;
    blk_bytes_nxt  = blk_bytes_r;
    base_nxt       = base_r;
    count_nxt      = count_r;
    low_nxt        = low_r;
    pos_nxt        = pos_r;
    fresh_nxt      = fresh_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;

    if (cfg_write_enable) begin
      case (cfg_index)
        REG_BLK_BYTES:    blk_bytes_nxt = cfg_data[SIZE_W-1:0];
        REG_BASE_ADDRESS: base_nxt      = cfg_data;
        default:          base_nxt      = base_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_addr_nxt = '0;
          if (in_action == ACT_ALLOC) begin
            if (in_request_size == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_SIZE_ZERO;
            end else if (in_request_size > blk_bytes_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_TOO_BIG;
            end else if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NO_BLOCK;
            end else begin
              mem_re    = 1'b1;
              count_nxt = count_m1;
              pos_nxt   = count_m1;
              fresh_nxt = count_m1 < low_r;
              if (count_m1 < low_r) begin
                low_nxt = count_m1;
              end
              state_nxt = S_POP;
            end
          end else begin
            if (in_address_is_null) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NULL_FREE;
            end else if ({1'b0, count_r} >= (CW+1)'(NUM_BLOCKS)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_FULL;
            end else begin
              quo_nxt   = sum[ADDR_W-1:0];
              rem_nxt   = '0;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_POP: begin
        if ({1'b0, popped} >= (IDX_W+1)'(NUM_BLOCKS)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = STAT_BAD_INDEX;
            state_nxt      = S_IDLE;
          end
        end else begin
          idx_nxt   = popped;
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt  = sum[ADDR_W-1:0];
        idx_nxt  = {idx_r[IDX_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(IDX_W - 1)) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = sum[ADDR_W-1:0];
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? sum[STRIDE_W-1:0] : {rem_r[STRIDE_W-2:0], quo_r[ADDR_W-1]};
        quo_nxt  = {quo_r[ADDR_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ADDR_W - 1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          mem_we         = 1'b1;
          count_nxt      = count_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      blk_bytes_r  <= SIZE_W'(BLK_BYTES_RESET);
      base_r       <= '0;
      count_r      <= CW'(NUM_BLOCKS);
      low_r        <= CW'(NUM_BLOCKS);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      blk_bytes_r  <= blk_bytes_nxt;
      base_r       <= base_nxt;
      count_r      <= count_nxt;
      low_r        <= low_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    fresh_r      <= fresh_nxt;
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // free index stack
  assign rd_addr = count_m1[AW-1:0];
  assign wr_addr = count_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= quo_r[IDX_W-1:0];
    end
    if (mem_re) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

@@ sim/tb_fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int unsigned POOL_BLOCKS = 8;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } pool_result_t;

  typedef struct packed {
    logic              act;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] faddr;
    logic              is_null;
    logic              typed;
    logic [ADDR_W-1:0] exp_addr;
    status_t           exp_status;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_write_enable;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [SIZE_W-1:0]    in_request_size;
  logic [ADDR_W-1:0]    in_free_address;
  logic                 in_address_is_null;
  logic                 out_valid;
  logic                 out_ready;
  logic [ADDR_W-1:0]    out_block_address;
  logic [2:0]           out_status;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS(POOL_BLOCKS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_request_size   (in_request_size),
    .in_free_address   (in_free_address),
    .in_address_is_null(in_address_is_null),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_address (out_block_address),
    .out_status        (out_status)
  );

  // shadow of the pool
  logic [IDX_W-1:0]  free_stack [POOL_BLOCKS];
  int unsigned       free_depth;
  logic [SIZE_W-1:0] pool_blk_bytes;
  logic [ADDR_W-1:0] pool_base;

  pool_result_t      pending_results [$];
  logic [ADDR_W-1:0] live_blocks [$];
  int unsigned       mismatch_count;
  bit                quiet_tail;
  bit                long_hold_req;

  directed_row_t directed_rows [24] = '{
    '{ACT_ALLOC, 16'd0,     32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_SIZE_ZERO},
    '{ACT_ALLOC, 16'd129,   32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_TOO_BIG},
    '{ACT_ALLOC, 16'hFFFF,  32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_TOO_BIG},
    '{ACT_FREE,  16'd0,     32'hFFFF_FFFF, 1'b1, TYPED, 32'd0,    STAT_NULL_FREE},
    '{ACT_FREE,  16'hFFFF,  32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_FULL},
    '{ACT_ALLOC, 16'd128,   32'hFFFF_FFFF, 1'b1, TYPED, 32'd1120, STAT_OK},
    '{ACT_ALLOC, 16'd1,     32'h0000_0000, 1'b0, TYPED, 32'd960,  STAT_OK},
    '{ACT_ALLOC, 16'd64,    32'h1234_5678, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd100,   32'h0000_0000, 1'b1, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd2,     32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd127,   32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd50,    32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'h0080,  32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd1,     32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_NO_BLOCK},
    '{ACT_FREE,  16'd0,     32'h0000_0000, 1'b1, TYPED, 32'd0,    STAT_NULL_FREE},
    '{ACT_FREE,  16'd0,     32'hFFFF_FFFF, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd5,     32'h0000_0000, 1'b0, TYPED, 32'd0,    STAT_BAD_INDEX},
    '{ACT_FREE,  16'd0,     32'd1120,      1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_FREE,  16'd0,     32'd1279,      1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd128,   32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd10,    32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_FREE,  16'd0,     32'd160,       1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_FREE,  16'd0,     32'h0000_A000, 1'b0, PREDICTED, 32'd0, STAT_OK},
    '{ACT_ALLOC, 16'd7,     32'h0000_0000, 1'b0, PREDICTED, 32'd0, STAT_OK}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] pool_stride();
    return ADDR_W'(pool_blk_bytes) + RED_ZONE;
  endfunction

  function automatic pool_result_t predict_pool(input logic act, input logic [SIZE_W-1:0] size,
                                                input logic [ADDR_W-1:0] faddr,
                                                input logic is_null);
    pool_result_t res;
    logic [IDX_W-1:0] idx;
    res.addr = '0;
    res.status = STAT_OK;
    if (act == ACT_ALLOC) begin
      if (size == 0) begin
        res.status = STAT_SIZE_ZERO;
      end else if (size > pool_blk_bytes) begin
        res.status = STAT_TOO_BIG;
      end else if (free_depth == 0) begin
        res.status = STAT_NO_BLOCK;
      end else begin
        free_depth--;
        idx = free_stack[free_depth];
        if (idx >= POOL_BLOCKS) begin
          res.status = STAT_BAD_INDEX;
        end else begin
          res.addr = pool_base + ADDR_W'(idx) * pool_stride();
        end
      end
    end else if (is_null) begin
      res.status = STAT_NULL_FREE;
    end else begin
      idx = IDX_W'((faddr - pool_base) / pool_stride());
      if (free_depth >= POOL_BLOCKS) begin
        res.status = STAT_FULL;
      end else begin
        free_stack[free_depth] = idx;
        free_depth++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input logic act, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] faddr, input logic is_null,
                           input logic typed, input pool_result_t typed_res);
    pool_result_t res;
    in_valid           <= 1'b1;
    in_action          <= act;
    in_request_size    <= size;
    in_free_address    <= faddr;
    in_address_is_null <= is_null;
    do @(posedge clk); while (!in_ready);
    res = predict_pool(act, size, faddr, is_null);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    if (act == ACT_ALLOC && res.status == STAT_OK) live_blocks.push_back(res.addr);
  endtask

  task automatic maybe_idle();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] bsize, input logic [ADDR_W-1:0] base);
    cfg_write_enable <= 1'b1;
    cfg_index        <= REG_BLK_BYTES;
    cfg_data         <= ADDR_W'(bsize);
    @(posedge clk);
    cfg_index        <= REG_BASE_ADDRESS;
    cfg_data         <= base;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    pool_blk_bytes = bsize;
    pool_base = base;
    live_blocks.delete();
  endtask

  task automatic send_random_item();
    logic              act;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] faddr;
    logic              is_null;
    int unsigned       pick;
    int unsigned       k;
    act = ACT_ALLOC;
    size = SIZE_W'($urandom);
    faddr = $urandom;
    is_null = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      size = SIZE_W'($urandom_range(1, pool_blk_bytes));
    end else if (pick < 44) begin
      size = '0;
    end else if (pick < 48) begin
      if (pool_blk_bytes == 16'hFFFF) size = 16'hFFFF;
      else size = SIZE_W'($urandom_range(32'(pool_blk_bytes) + 1, 65535));
    end else if (pick < 50) begin
      // random size, left as drawn
    end else if (pick < 85) begin
      act = ACT_FREE;
      is_null = 1'b0;
      if (live_blocks.size() == 0) begin
        faddr = pool_base + pool_stride() * $urandom_range(0, POOL_BLOCKS - 1);
      end else begin
        k = $urandom_range(0, live_blocks.size() - 1);
        faddr = live_blocks[k] + $urandom_range(0, pool_stride() - 1);
        // occasional double free keeps the block on the list
        if ($urandom_range(0, 9) != 0) live_blocks.delete(k);
      end
    end else if (pick < 92) begin
      act = ACT_FREE;
      is_null = 1'b1;
    end else begin
      act = ACT_FREE;
      is_null = 1'b0;
    end
    send_item(act, size, faddr, is_null, PREDICTED, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat addr %h status %0d",
                                  out_block_address, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_block_address !== want.addr)
          report_mismatch($sformatf("block_address %h, want %h", out_block_address, want.addr));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
      end
    end
  end

  // receiver
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // sender
  initial begin
    logic [SIZE_W-1:0] phase_size [6];
    logic [ADDR_W-1:0] phase_base [6];
    pool_result_t      typed_res;
    mismatch_count = 0;
    quiet_tail = 1'b0;
    long_hold_req = 1'b0;
    pool_blk_bytes = BLK_BYTES_RESET;
    pool_base = '0;
    free_depth = POOL_BLOCKS;
    for (int i = 0; i < POOL_BLOCKS; i++) free_stack[i] = IDX_W'(i);

    rst_n              <= 1'b0;
    cfg_write_enable   <= 1'b0;
    cfg_index          <= REG_BLK_BYTES;
    cfg_data           <= '0;
    in_valid           <= 1'b0;
    in_action          <= ACT_ALLOC;
    in_request_size    <= '0;
    in_free_address    <= '0;
    in_address_is_null <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      maybe_idle();
      typed_res.addr = directed_rows[i].exp_addr;
      typed_res.status = directed_rows[i].exp_status;
      send_item(directed_rows[i].act, directed_rows[i].size, directed_rows[i].faddr,
                directed_rows[i].is_null, directed_rows[i].typed, typed_res);
    end

    phase_size = '{16'd1, 16'hFFFF, SIZE_W'($urandom_range(1, 65535)),
                   SIZE_W'($urandom_range(1, 4096)), 16'd128, 16'hFFFF};
    phase_base = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom,
                   32'hFFFF_0000, 32'hFFFF_FFFF};

    for (int p = 0; p < 6; p++) begin
      drain();
      configure(phase_size[p], phase_base[p]);
      if (p == 5) quiet_tail = 1'b1;
      if (p == 1) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        if (!(p == 1 && n < 40)) maybe_idle();
        send_random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fbpa_pkg.sv
src/fixed_block_pool_allocator.sv
sim/tb_fixed_block_pool_allocator.sv
